>>> design/thp_pkg.sv
// Shared types, constants and helpers for the THP compensation pipeline.
`default_nettype none

package thp_pkg;

  localparam int DIV_STAGES = 32;
  localparam int PRE_LAT    = 6;
  localparam int POST_LAT   = 3;
  localparam int PRESS_LAT  = PRE_LAT + DIV_STAGES + POST_LAT;
  localparam int HUM_LAT    = 9;
  localparam int HUM_PAD    = PRESS_LAT - HUM_LAT;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_P9  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM       = 3'd4;

  localparam logic [31:0] K_64000   = 32'd64000;
  localparam logic [31:0] K_2POW20  = 32'd1048576;
  localparam logic [31:0] K_3125    = 32'd3125;
  localparam logic [31:0] K_32768   = 32'd32768;
  localparam logic [31:0] K_76800   = 32'd76800;
  localparam logic [31:0] K_16384   = 32'd16384;
  localparam logic [31:0] K_2POW21  = 32'd2097152;
  localparam logic [31:0] K_8192    = 32'd8192;
  localparam logic [31:0] K_HUM_MAX = 32'd419430400;
  localparam logic [31:0] K_128     = 32'd128;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
  } temp_cal_t;

  typedef struct packed {
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } press_cal_t;

  typedef struct packed {
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } hum_cal_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic [31:0] v1p;
    logic [31:0] q;
    logic [31:0] hx;
    logic [19:0] ap;
    logic [15:0] ah;
  } front_t;

  typedef struct packed {
    logic dbl;
    logic zero;
  } div_tag_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic [31:0] press;
    logic [16:0] hum;
  } result_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  function automatic logic [31:0] zx16(input logic [15:0] x);
    return {16'd0, x};
  endfunction

  function automatic logic [31:0] zx12(input logic [11:0] x);
    return {20'd0, x};
  endfunction

  function automatic logic [31:0] zx8(input logic [7:0] x);
    return {24'd0, x};
  endfunction

endpackage

`default_nettype wire

>>> design/thp_sensor_compensation.sv
// Top level: configuration registers, compensation pipeline and output queue.
`default_nettype none

// Integer compensation of raw temperature, pressure and humidity readings.
// One item is taken per clock while in_stall is low. The depth comes mostly
// from the pressure divider, which resolves one quotient bit per stage over
// 32 stages. A two-entry queue sits at the output, so the pipeline keeps
// moving while one result waits; in_stall rises only when both entries are
// held. Write the coefficient registers only while no item is in flight.

module thp_sensor_compensation import thp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [19:0]           in_raw_temp,
  input  wire logic [19:0]           in_raw_press,
  input  wire logic [15:0]           in_raw_hum,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                out_temp_centi,
  output logic [31:0]                out_fine_temp,
  output logic [31:0]                out_press_pa,
  output logic [16:0]                out_hum_q22_10
);

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_low_r, press_mid_r, hum_coeffs_r;
  logic [15:0] press_nine_r;
  temp_cal_t   tcal;
  press_cal_t  pcal;
  hum_cal_t    hcal;

  logic        en;
  logic        fr_valid, pr_valid;
  front_t      fr;
  logic [31:0] press;
  logic [16:0] hum;
  logic [63:0] tf_r [0:PRESS_LAT-1];
  result_t     push_data;
  result_t     q_r [0:1];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_low_r   <= '0;
      press_mid_r   <= '0;
      press_nine_r  <= '0;
      hum_coeffs_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP:      temp_coeffs_r <= cfg_data[47:0];
        CFG_PRESS_LOW: press_low_r   <= cfg_data;
        CFG_PRESS_MID: press_mid_r   <= cfg_data;
        CFG_PRESS_P9:  press_nine_r  <= cfg_data[15:0];
        CFG_HUM:       hum_coeffs_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tcal.t1 = temp_coeffs_r[15:0];
    tcal.t2 = temp_coeffs_r[31:16];
    tcal.t3 = temp_coeffs_r[47:32];
    pcal.p1 = press_low_r[15:0];
    pcal.p2 = press_low_r[31:16];
    pcal.p3 = press_low_r[47:32];
    pcal.p4 = press_low_r[63:48];
    pcal.p5 = press_mid_r[15:0];
    pcal.p6 = press_mid_r[31:16];
    pcal.p7 = press_mid_r[47:32];
    pcal.p8 = press_mid_r[63:48];
    pcal.p9 = press_nine_r;
    hcal.h1 = hum_coeffs_r[7:0];
    hcal.h2 = hum_coeffs_r[23:8];
    hcal.h3 = hum_coeffs_r[31:24];
    hcal.h4 = hum_coeffs_r[43:32];
    hcal.h5 = hum_coeffs_r[55:44];
    hcal.h6 = hum_coeffs_r[63:56];
  end

  // advance the whole pipeline unless the output queue is full
  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;

  thp_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .raw_temp  (in_raw_temp),
    .raw_press (in_raw_press),
    .raw_hum   (in_raw_hum),
    .cal       (tcal),
    .out_valid (fr_valid),
    .out_data  (fr)
  );

  thp_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .fr        (fr),
    .cal       (pcal),
    .out_valid (pr_valid),
    .press_pa  (press)
  );

  thp_hum u_hum (
    .clk        (clk),
    .en         (en),
    .fr         (fr),
    .cal        (hcal),
    .hum_q22_10 (hum)
  );

  // carry temperature results alongside the pressure path
  always_ff @(posedge clk) begin
    if (en) begin
      tf_r[0] <= {fr.tc, fr.fine};
      for (int i = 1; i < PRESS_LAT; i++) begin
        tf_r[i] <= tf_r[i-1];
      end
    end
  end

  always_comb begin
    push_data.tc    = tf_r[PRESS_LAT-1][63:32];
    push_data.fine  = tf_r[PRESS_LAT-1][31:0];
    push_data.press = press;
    push_data.hum   = hum;
  end

  assign push = en && pr_valid;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_temp_centi = q_r[rd_ptr_r].tc;
  assign out_fine_temp  = q_r[rd_ptr_r].fine;
  assign out_press_pa   = q_r[rd_ptr_r].press;
  assign out_hum_q22_10 = q_r[rd_ptr_r].hum;

endmodule

`default_nettype wire

>>> design/thp_temp.sv
// Temperature stages: fine temperature, 0.01 degC value and shared terms.
`default_nettype none

module thp_temp import thp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [19:0] raw_temp,
  input  wire logic [19:0] raw_press,
  input  wire logic [15:0] raw_hum,
  input  wire temp_cal_t   cal,
  output logic             out_valid,
  output front_t           out_data
);

  logic [31:0] t1, t2, t3;
  logic [31:0] a_nxt, d_nxt;
  logic [31:0] m1_r, dd_r, v1_r, m2_r, fine_r;
  logic [19:0] ap1_r, ap2_r, ap3_r;
  logic [15:0] ah1_r, ah2_r, ah3_r;
  logic [2:0]  vld_r;
  logic        vo_r;
  front_t      fr_nxt, fr_r;

  assign t1 = zx16(cal.t1);
  assign t2 = sx16(cal.t2);
  assign t3 = sx16(cal.t3);

  always_comb begin
    a_nxt = {15'd0, raw_temp[19:3]} - {t1[30:0], 1'b0};
    d_nxt = {16'd0, raw_temp[19:4]} - t1;
    fr_nxt.fine = fine_r;
    fr_nxt.tc   = asr((fine_r << 2) + fine_r + K_128, 5'd8);
    fr_nxt.v1p  = asr(fine_r, 5'd1) - K_64000;
    fr_nxt.q    = asr(asr(fine_r, 5'd1) - K_64000, 5'd2);
    fr_nxt.hx   = fine_r - K_76800;
    fr_nxt.ap   = ap3_r;
    fr_nxt.ah   = ah3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vo_r  <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
      vo_r  <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= a_nxt * t2;
      dd_r   <= d_nxt * d_nxt;
      ap1_r  <= raw_press;
      ah1_r  <= raw_hum;
      v1_r   <= asr(m1_r, 5'd11);
      m2_r   <= asr(dd_r, 5'd12) * t3;
      ap2_r  <= ap1_r;
      ah2_r  <= ah1_r;
      fine_r <= v1_r + asr(m2_r, 5'd14);
      ap3_r  <= ap2_r;
      ah3_r  <= ah2_r;
      fr_r   <= fr_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = fr_r;

endmodule

`default_nettype wire

>>> design/thp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module thp_div import thp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  input  wire div_tag_t    in_tag,
  output logic             out_valid,
  output logic [31:0]      quotient,
  output div_tag_t         out_tag
);

  logic [31:0] rem_s [0:DIV_STAGES];
  logic [31:0] dq_s  [0:DIV_STAGES];
  logic [31:0] dvs_s [0:DIV_STAGES];
  div_tag_t    tag_s [0:DIV_STAGES];
  logic [DIV_STAGES:0] vld_s;

  assign rem_s[0] = '0;
  assign dq_s[0]  = dividend;
  assign dvs_s[0] = divisor;
  assign tag_s[0] = in_tag;
  assign vld_s[0] = in_valid;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [32:0] trial, diff;
    logic        ge;
    logic [31:0] rem_r, dq_r, dvs_r;
    div_tag_t    tag_r;
    logic        vld_r;

    always_comb begin
      trial = {rem_s[k], dq_s[k][31]};
      diff  = trial - {1'b0, dvs_s[k]};
      ge    = !diff[32];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? diff[31:0] : trial[31:0];
        dq_r  <= {dq_s[k][30:0], ge};
        dvs_r <= dvs_s[k];
        tag_r <= tag_s[k];
      end
    end

    assign rem_s[k+1] = rem_r;
    assign dq_s[k+1]  = dq_r;
    assign dvs_s[k+1] = dvs_r;
    assign tag_s[k+1] = tag_r;
    assign vld_s[k+1] = vld_r;
  end

  assign out_valid = vld_s[DIV_STAGES];
  assign quotient  = dq_s[DIV_STAGES];
  assign out_tag   = tag_s[DIV_STAGES];

endmodule

`default_nettype wire

>>> design/thp_press.sv
// Pressure path: variable terms, dividend scaling, divider and final correction.
`default_nettype none

module thp_press import thp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire front_t      fr,
  input  wire press_cal_t  cal,
  output logic             out_valid,
  output logic [31:0]      press_pa
);

  logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [5:0]  vld_r;
  logic [31:0] sq_r, m5_r, m2_r, m5b_r, m2b_r, v2a_r, m3_r;
  logic [19:0] ap5_r, ap6_r, ap7_r;
  logic [31:0] v2_r, s_r, pr_r, n_r, dv_r, pd_r;
  logic [31:0] dvd_r, dvs_r;
  div_tag_t    tag_r;
  logic [31:0] sum_nxt, v1_nxt;
  logic        dq_valid;
  logic [31:0] quo, pq_nxt;
  div_tag_t    dtag;
  logic [2:0]  pv_r;
  logic [31:0] t_r, m8_r, pa_r, m9_r, a8_r, pb_r, out_r;
  logic        za_r, zb_r;

  assign p1 = zx16(cal.p1);
  assign p2 = sx16(cal.p2);
  assign p3 = sx16(cal.p3);
  assign p4 = sx16(cal.p4);
  assign p5 = sx16(cal.p5);
  assign p6 = sx16(cal.p6);
  assign p7 = sx16(cal.p7);
  assign p8 = sx16(cal.p8);
  assign p9 = sx16(cal.p9);

  always_comb begin
    sum_nxt = v2a_r + {m5b_r[30:0], 1'b0};
    v1_nxt  = asr(asr(m3_r, 5'd3) + asr(m2b_r, 5'd1), 5'd18);
    pq_nxt  = dtag.dbl ? {quo[30:0], 1'b0} : quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      pv_r  <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
      pv_r  <= {pv_r[1:0], dq_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= fr.q * fr.q;
      m5_r  <= fr.v1p * p5;
      m2_r  <= p2 * fr.v1p;
      ap5_r <= fr.ap;

      v2a_r <= asr(sq_r, 5'd11) * p6;
      m3_r  <= p3 * asr(sq_r, 5'd13);
      m5b_r <= m5_r;
      m2b_r <= m2_r;
      ap6_r <= ap5_r;

      v2_r  <= asr(sum_nxt, 5'd2) + {p4[15:0], 16'd0};
      s_r   <= K_32768 + v1_nxt;
      ap7_r <= ap6_r;

      pr_r  <= s_r * p1;
      n_r   <= (K_2POW20 - {12'd0, ap7_r}) - asr(v2_r, 5'd12);

      dv_r  <= asr(pr_r, 5'd15);
      pd_r  <= n_r * K_3125;

      // large dividend: divide first, double afterwards
      dvd_r     <= pd_r[31] ? pd_r : {pd_r[30:0], 1'b0};
      tag_r.dbl <= pd_r[31];
      tag_r.zero <= (dv_r == 32'd0);
      dvs_r     <= dv_r;

      t_r   <= {3'd0, pq_nxt[31:3]} * {3'd0, pq_nxt[31:3]};
      m8_r  <= {2'd0, pq_nxt[31:2]} * p8;
      pa_r  <= pq_nxt;
      za_r  <= dtag.zero;

      m9_r  <= p9 * (t_r >> 13);
      a8_r  <= asr(m8_r, 5'd13);
      pb_r  <= pa_r;
      zb_r  <= za_r;

      out_r <= zb_r ? 32'd0 : pb_r + asr(asr(m9_r, 5'd12) + a8_r + p7, 5'd4);
    end
  end

  thp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_r[5]),
    .dividend  (dvd_r),
    .divisor   (dvs_r),
    .in_tag    (tag_r),
    .out_valid (dq_valid),
    .quotient  (quo),
    .out_tag   (dtag)
  );

  assign out_valid = pv_r[2];
  assign press_pa  = out_r;

endmodule

`default_nettype wire

>>> design/thp_hum.sv
// Humidity path with clamp, padded to the pressure path latency.
`default_nettype none

module thp_hum import thp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire front_t      fr,
  input  wire hum_cal_t    cal,
  output logic [16:0]      hum_q22_10
);

  logic [31:0] h1, h2, h3, h4, h5, h6;
  logic [31:0] m5_r, m6_r, m3_r, a_r, u_r, w_r;
  logic [15:0] ah_r;
  logic [31:0] b0_r, a3_r, b1_r, a4_r, b_r, a5_r;
  logic [31:0] xm_r, sq_r, x7_r, m_r, x8_r;
  logic [31:0] sh_nxt, xf_nxt;
  logic [16:0] hum_r;
  logic [16:0] pad_r [0:HUM_PAD-1];

  assign h1 = zx8(cal.h1);
  assign h2 = sx16(cal.h2);
  assign h3 = zx8(cal.h3);
  assign h4 = zx12(cal.h4);
  assign h5 = zx12(cal.h5);
  assign h6 = sx8(cal.h6);

  always_comb begin
    sh_nxt = asr(xm_r, 5'd15);
    xf_nxt = x8_r - asr(m_r, 5'd4);
    if (xf_nxt[31]) begin
      xf_nxt = 32'd0;
    end
    if (xf_nxt > K_HUM_MAX) begin
      xf_nxt = K_HUM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_r <= h5 * fr.hx;
      m6_r <= fr.hx * h6;
      m3_r <= fr.hx * h3;
      ah_r <= fr.ah;

      a_r  <= asr({2'd0, ah_r, 14'd0} - {h4[11:0], 20'd0} - m5_r + K_16384, 5'd15);
      u_r  <= asr(m3_r, 5'd11) + K_32768;
      w_r  <= asr(m6_r, 5'd10);

      b0_r <= w_r * u_r;
      a3_r <= a_r;

      b1_r <= (asr(b0_r, 5'd10) + K_2POW21) * h2;
      a4_r <= a3_r;

      b_r  <= asr(b1_r + K_8192, 5'd14);
      a5_r <= a4_r;

      xm_r <= a5_r * b_r;

      sq_r <= sh_nxt * sh_nxt;
      x7_r <= xm_r;

      m_r  <= asr(sq_r, 5'd7) * h1;
      x8_r <= x7_r;

      hum_r <= xf_nxt[28:12];

      pad_r[0] <= hum_r;
      for (int i = 1; i < HUM_PAD; i++) begin
        pad_r[i] <= pad_r[i-1];
      end
    end
  end

  assign hum_q22_10 = pad_r[HUM_PAD-1];

endmodule

`default_nettype wire

>>> design/thp_chk.sv
// Port-level checks for the compensation block, bound to the top level.
`default_nettype none

module thp_chk import thp_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [31:0]           out_temp_centi,
  input wire logic [31:0]           out_press_pa,
  input wire logic [16:0]           out_hum_q22_10
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_temp_centi) && $stable(out_press_pa))
    else $error("stalled result changed");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hum_q22_10 <= 17'd102400)
    else $error("humidity above full scale");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind thp_sensor_compensation thp_chk u_thp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_temp_centi (out_temp_centi),
  .out_press_pa   (out_press_pa),
  .out_hum_q22_10 (out_hum_q22_10)
);

`default_nettype wire
